### design/ipidaw_pkg.sv
// ----------------------------------------------------------------------------
// ipidaw_pkg: shared definitions for the incremental PID unit
// Widths, fixed limits and configuration register indexes.
// ----------------------------------------------------------------------------
package ipidaw_pkg;

  localparam int CHANNELS       = 4;
  localparam int CH_W           = $clog2(CHANNELS);
  localparam int GAIN_FRAC_BITS = 12;

  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 10;
  localparam int IN_W    = 16;
  localparam int ERR_W   = 17;
  localparam int DIFF1_W = 18;
  localparam int DIFF2_W = 20;
  localparam int DRV_W   = 16;
  localparam int ACC_W   = 38;
  localparam int CFG_W   = 16;

  localparam logic signed [ACC_W-1:0] FAULT_LOW  = -ACC_W'(10000);
  localparam logic signed [ACC_W-1:0] FAULT_HIGH = ACC_W'(5000);

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_WINDUP_HIGH = 3'd3,
    REG_WINDUP_LOW  = 3'd4,
    REG_OUT_HIGH    = 3'd5,
    REG_OUT_LOW     = 3'd6
  } cfg_reg_t;

endpackage

### design/incremental_pid_antiwindup_fault_unit.sv
// ----------------------------------------------------------------------------
// incremental_pid_antiwindup_fault_unit: multi-channel velocity-form PID
// Per-channel incremental PID with integral anti-windup, output clamping and
// a runaway fault that clears the channel state.
// ----------------------------------------------------------------------------
// Usage:
// Each input item (channel, measured, setpoint) is taken on the in_valid /
// in_stall channel and produces exactly one result item (drive, fault_reset)
// on the out_valid / out_stall channel, in input order.
// The block has two register stages: an input register, then one pass of
// logic (error, three gain multiplies, sum, shift, fault test and clamp)
// that loads the result register and updates the channel state at the same
// edge. out_valid rises at the edge that moves the item out of the input
// register, and one item can be accepted every cycle while the receiver
// does not stall.
// Because the state is written when an item moves into the result register,
// the next item on the same channel already sees it, even back to back.
// When the receiver stalls, the result register holds its item; the input
// register still takes one more item, and in_stall rises only when both are
// full. Synchronous reset clears all valid flags, all channel state to zero
// and the gains and limits to their defaults. Configuration writes are meant
// to be made while no item is in flight.
module incremental_pid_antiwindup_fault_unit
  import ipidaw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                channel,
  input  logic signed [IN_W-1:0]    measured,
  input  logic signed [IN_W-1:0]    setpoint,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LIM_W-1:0]          drive,
  output logic                      fault_reset
);

  // Configuration registers.
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;
  logic signed [GAIN_W-1:0] deriv_gain;
  logic [LIM_W-1:0]         windup_high;
  logic [LIM_W-1:0]         windup_low;
  logic [LIM_W-1:0]         out_high;
  logic [LIM_W-1:0]         out_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= GAIN_W'(614);
      integ_gain  <= GAIN_W'(12);
      deriv_gain  <= '0;
      windup_high <= LIM_W'(980);
      windup_low  <= LIM_W'(100);
      out_high    <= LIM_W'(980);
      out_low     <= LIM_W'(100);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:   prop_gain   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        REG_WINDUP_HIGH: windup_high <= cfg_data[LIM_W-1:0];
        REG_WINDUP_LOW:  windup_low  <= cfg_data[LIM_W-1:0];
        REG_OUT_HIGH:    out_high    <= cfg_data[LIM_W-1:0];
        REG_OUT_LOW:     out_low     <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The input register advances into the result register whenever
  // the result register is empty or is being emptied this cycle.
  logic s0_valid;
  logic s1_free;
  logic advance;

  assign s1_free  = !out_valid || !out_stall;
  assign in_stall = s0_valid && !s1_free;
  assign advance  = s0_valid && s1_free;

  // Input register.
  logic [CH_W-1:0]          s0_ch;
  logic signed [IN_W-1:0]   s0_measured;
  logic signed [IN_W-1:0]   s0_setpoint;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!in_stall) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s0_ch       <= channel[CH_W-1:0];
      s0_measured <= measured;
      s0_setpoint <= setpoint;
    end
  end

  // Channel state.
  logic signed [ERR_W-1:0] err_last        [CHANNELS];
  logic signed [ERR_W-1:0] err_before_last [CHANNELS];
  logic signed [DRV_W-1:0] drive_last      [CHANNELS];

  // Single pass of the control law.
  logic signed [ERR_W-1:0]            err;
  logic signed [ERR_W-1:0]            e1;
  logic signed [ERR_W-1:0]            e2;
  logic signed [DRV_W-1:0]            prev;
  logic signed [DIFF1_W-1:0]          diff1;
  logic signed [DIFF2_W-1:0]          diff2;
  logic signed [GAIN_W+DIFF1_W-1:0]   p_prod;
  logic signed [GAIN_W+ERR_W-1:0]     i_prod;
  logic signed [GAIN_W+DIFF2_W-1:0]   d_prod;
  logic signed [DRV_W-1:0]            wh_s;
  logic signed [DRV_W-1:0]            wl_s;
  logic                               integ_block;
  logic signed [ACC_W-1:0]            acc;
  logic signed [ACC_W-1:0]            u;
  logic signed [ACC_W-1:0]            oh_s;
  logic signed [ACC_W-1:0]            ol_s;
  logic                               fault;
  logic [LIM_W-1:0]                   drive_next;

  assign e1   = err_last[s0_ch];
  assign e2   = err_before_last[s0_ch];
  assign prev = drive_last[s0_ch];

  assign err   = ERR_W'(s0_setpoint) - ERR_W'(s0_measured);
  assign diff1 = DIFF1_W'(err) - DIFF1_W'(e1);
  assign diff2 = DIFF2_W'(err) - (DIFF2_W'(e1) <<< 1) + DIFF2_W'(e2);

  assign p_prod = prop_gain * diff1;
  assign i_prod = integ_gain * err;
  assign d_prod = deriv_gain * diff2;

  // Integral is held off while the previous drive sits in a windup zone and
  // the error would push it further in.
  assign wh_s = {{(DRV_W-LIM_W){1'b0}}, windup_high};
  assign wl_s = {{(DRV_W-LIM_W){1'b0}}, windup_low};
  assign integ_block = ((prev >= wh_s) && !err[ERR_W-1]) ||
                       ((prev <= wl_s) && (err[ERR_W-1] || (err == '0)));

  assign acc = ACC_W'(p_prod) + ACC_W'(d_prod) +
               (integ_block ? '0 : ACC_W'(i_prod));

  // Arithmetic shift rounds toward minus infinity.
  assign u = ACC_W'(prev) + (acc >>> GAIN_FRAC_BITS);

  assign fault = (u < FAULT_LOW) || (u > FAULT_HIGH);

  // Fault first; then the upper bound wins where an inverted pair overlaps.
  assign oh_s = {{(ACC_W-LIM_W){1'b0}}, out_high};
  assign ol_s = {{(ACC_W-LIM_W){1'b0}}, out_low};
  always_comb begin
    if (fault) begin
      drive_next = {1'b0, out_high[LIM_W-1:1]};
    end else if (u >= oh_s) begin
      drive_next = out_high;
    end else if (u <= ol_s) begin
      drive_next = out_low;
    end else begin
      drive_next = u[LIM_W-1:0];
    end
  end

  // State update happens at the same edge that loads the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        err_last[i]        <= '0;
        err_before_last[i] <= '0;
        drive_last[i]      <= '0;
      end
    end else if (advance) begin
      if (fault) begin
        err_last[s0_ch]        <= '0;
        err_before_last[s0_ch] <= '0;
        drive_last[s0_ch]      <= '0;
      end else begin
        err_before_last[s0_ch] <= e1;
        err_last[s0_ch]        <= err;
        drive_last[s0_ch]      <= u[DRV_W-1:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_free) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive       <= drive_next;
      fault_reset <= fault;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s0_valid)
    else $error("input stalled with an empty input register");

  a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result register was empty");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_valid && (fault_reset == $past(fault))))
    else $error("item moved without a matching result");

  a_fault_clears_state: assert property (@(posedge clk) disable iff (rst)
    (advance && fault) |=> ((drive_last[$past(s0_ch)] == '0) &&
                            (err_last[$past(s0_ch)] == '0) &&
                            (err_before_last[$past(s0_ch)] == '0)))
    else $error("fault did not clear the channel state");
`endif

endmodule
